// ----- hdl/assert_macros.svh -----
// Assertion helpers. Both expect clk and rst_n to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/shsls_pkg.sv -----
package shsls_pkg;

    // tdata widths, padded to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    localparam int ANGLE_W  = 16;
    localparam int PHASES_W = 16;
    localparam int NIBBLE_W = 4;
    localparam int SWITCH_W = 8;
    localparam int LIMIT_W  = 3;
    localparam int PHASE_W  = 3;

    // floor(a / 45) == (a * 46604) >> 21 for every 16-bit a
    localparam logic [ANGLE_W-1:0] DIV45_RECIP = 16'd46604;
    localparam int DIV45_SHIFT = 21;
    localparam int PROD_W      = 2 * ANGLE_W;
    localparam int STEPS_W     = PROD_W - DIV45_SHIFT;
    // 32 phases per step
    localparam int PHASE_PER_STEP_SHIFT = 5;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // config register indexes
    localparam logic CFG_OPEN_LIMIT  = 1'b0;
    localparam logic CFG_CLOSE_LIMIT = 1'b1;

    // item kinds on s_tuser
    localparam logic MODE_CMD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [0:0] {
        BK_RUN,
        BK_FINAL
    } back_state_t;

    // classified item as it sits in the queue
    typedef struct packed {
        logic                is_tick;
        logic                open_dir;
        logic [PHASES_W-1:0] phases;
        logic [NIBBLE_W-1:0] low_bits;
        logic [SWITCH_W-1:0] switch_byte;
    } queue_entry_t;

    function automatic logic [NIBBLE_W-1:0] half_step_nibble(input logic [PHASE_W-1:0] idx);
        logic [NIBBLE_W-1:0] pat;
        case (idx)
            3'd0:    pat = 4'h8;
            3'd1:    pat = 4'hC;
            3'd2:    pat = 4'h4;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h2;
            3'd5:    pat = 4'h3;
            3'd6:    pat = 4'h1;
            3'd7:    pat = 4'h9;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

// ----- hdl/shsls_front.sv -----
module shsls_front (
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [shsls_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tuser,
    input  logic                             q_full,
    output logic                             q_push,
    output shsls_pkg::queue_entry_t          q_entry
);
    import shsls_pkg::*;

    logic [ANGLE_W-1:0] angle;
    logic [PROD_W-1:0]  prod;
    logic [STEPS_W-1:0] steps;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // divide by 45 through the reciprocal; the queue register follows
    assign angle = s_tdata[16:1];
    assign prod  = angle * DIV45_RECIP;
    assign steps = prod[PROD_W-1:DIV45_SHIFT];

    always_comb
    begin
        q_entry.is_tick     = (s_tuser == MODE_TICK);
        q_entry.open_dir    = s_tdata[0];
        q_entry.phases      = PHASES_W'({steps, {PHASE_PER_STEP_SHIFT{1'b0}}});
        q_entry.low_bits    = s_tdata[20:17];
        q_entry.switch_byte = s_tdata[28:21];
    end

endmodule

// ----- hdl/shsls_queue.sv -----
module shsls_queue #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    `include "assert_macros.svh"

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_IMPLIES(a_q_no_underflow, pop, count_reg != '0)
    `ASSERT_NEXT(a_q_push_grows, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ----- hdl/shsls_back.sv -----
module shsls_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic                             cfg_addr,
    input  logic [shsls_pkg::LIMIT_W-1:0]    cfg_data,
    input  logic                             q_valid,
    input  shsls_pkg::queue_entry_t          q_entry,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [shsls_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                             m_tuser,
    output logic                             m_tlast
);
    import shsls_pkg::*;

    `include "assert_macros.svh"

    back_state_t state_reg, state_next;

    logic [LIMIT_W-1:0]  open_limit_reg, close_limit_reg;
    logic                running_reg, running_next;
    logic                opening_reg, opening_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [PHASES_W-1:0] left_reg, left_next;
    logic [NIBBLE_W-1:0] low_reg, low_next;
    logic                fin_hit_reg, fin_hit_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;
    logic                m_tlast_reg, m_tlast_next;

    logic                out_free;
    logic                load_out;
    logic [NIBBLE_W-1:0] pattern;
    logic [LIMIT_W-1:0]  limit_sel;
    logic                hit;
    logic [PHASES_W-1:0] left_dec;
    logic                tick_ends;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign q_pop    = (state_reg == BK_RUN) && q_valid && out_free;

    // opening runs walk the table backwards
    assign pattern   = half_step_nibble(opening_reg ? ~phase_reg : phase_reg);
    assign limit_sel = opening_reg ? open_limit_reg : close_limit_reg;
    assign hit       = q_entry.switch_byte[limit_sel];
    assign left_dec  = left_reg - 1'b1;
    assign tick_ends = q_entry.is_tick && running_reg && (hit || left_dec == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_RUN:
            begin
                if (q_pop && tick_ends)
                begin
                    state_next = BK_FINAL;
                end
            end
            BK_FINAL:
            begin
                if (out_free)
                begin
                    state_next = BK_RUN;
                end
            end
            default: state_next = BK_RUN;
        endcase
    end

    // run state and output beat
    always_comb
    begin
        running_next = running_reg;
        opening_next = opening_reg;
        phase_next   = phase_reg;
        left_next    = left_reg;
        low_next     = low_reg;
        fin_hit_next = fin_hit_reg;
        load_out     = 1'b0;
        m_tdata_next = m_tdata_reg;
        m_tuser_next = m_tuser_reg;
        m_tlast_next = m_tlast_reg;

        if (q_pop)
        begin
            if (!q_entry.is_tick)
            begin
                opening_next = q_entry.open_dir;
                low_next     = q_entry.low_bits;
                phase_next   = '0;
                left_next    = q_entry.phases;
                running_next = (q_entry.phases != '0);
                if (q_entry.phases == '0)
                begin
                    load_out     = 1'b1;
                    m_tdata_next = {{NIBBLE_W{1'b0}}, q_entry.low_bits};
                    m_tuser_next = 1'b0;
                    m_tlast_next = 1'b1;
                end
            end
            else if (running_reg)
            begin
                phase_next   = phase_reg + 1'b1;
                left_next    = left_dec;
                load_out     = 1'b1;
                m_tdata_next = {pattern, low_reg};
                m_tuser_next = hit;
                m_tlast_next = 1'b0;
                fin_hit_next = hit;
                if (tick_ends)
                begin
                    running_next = 1'b0;
                end
            end
        end
        else if (state_reg == BK_FINAL && out_free)
        begin
            load_out     = 1'b1;
            m_tdata_next = {{NIBBLE_W{1'b0}}, low_reg};
            m_tuser_next = fin_hit_reg;
            m_tlast_next = 1'b1;
        end

        m_tvalid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_RUN;
            open_limit_reg  <= '0;
            close_limit_reg <= '0;
            running_reg     <= 1'b0;
            opening_reg     <= 1'b0;
            phase_reg       <= '0;
            left_reg        <= '0;
            low_reg         <= '0;
            fin_hit_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            running_reg  <= running_next;
            opening_reg  <= opening_next;
            phase_reg    <= phase_next;
            left_reg     <= left_next;
            low_reg      <= low_next;
            fin_hit_reg  <= fin_hit_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_OPEN_LIMIT:  open_limit_reg  <= cfg_data;
                    CFG_CLOSE_LIMIT: close_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    `ASSERT_IMPLIES(a_final_has_beat, state_reg == BK_FINAL, m_tvalid_reg && !running_reg)
    `ASSERT_NEXT(a_end_goes_final, q_pop && tick_ends, state_reg == BK_FINAL && !m_tlast_reg)

endmodule

// ----- hdl/stepper_half_step_limit_sequencer_top.sv -----
// Half-step stepper sequencer with limit-switch stop. A command beat (tuser 0) sets
// direction, low nibble and run length: floor(angle / 45) steps of 32 phases each,
// where angle is in 1/16 degree. Each later tick beat (tuser 1) returns one output
// byte, the half-step pattern in the upper nibble over the kept low nibble, and tests
// the tick's switch byte at the configured limit bit. On a limit hit or the last
// phase, a second beat follows: the low nibble alone, with tlast set. A command
// whose run length is zero returns that off beat only; ticks while idle return
// nothing, and a command while running restarts the run. Input beats are taken one
// per cycle while the queue (two entries by default) has room; the back end retires
// one beat per cycle while its output is free, but a run-ending tick holds it until
// both results have gone through the single output register. Configure only while idle.
module stepper_half_step_limit_sequencer_top #(
    parameter int QUEUE_DEPTH = shsls_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // config: index 0 open limit bit, index 1 close limit bit
    input  logic                             cfg_we,
    input  logic                             cfg_addr,
    input  logic [shsls_pkg::LIMIT_W-1:0]    cfg_data,
    // input beats
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [0] open_dir, [16:1] angle_sixteenths, [20:17] kept_low_bits,
    // [28:21] switch_byte, [31:29] zero
    input  logic [shsls_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] mode
    input  logic                             s_tuser,
    // result beats
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] out_byte
    output logic [shsls_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] hit_limit
    output logic                             m_tuser,
    output logic                             m_tlast
);
    import shsls_pkg::*;

    queue_entry_t push_entry;
    queue_entry_t head_entry;
    logic         q_push;
    logic         q_full;
    logic         q_pop;
    logic         q_valid;

    // front: classify, scale angle to phase count
    shsls_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    // decouples front from back end stalls
    shsls_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(queue_entry_t))
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (head_entry),
        .not_empty (q_valid)
    );

    // back end: run state, pattern table, limit test, output register
    shsls_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .q_valid  (q_valid),
        .q_entry  (head_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
